// File: design/kec_pkg.sv
// Shared constants, types and the arctangent table for the kappa/eulerian converter.
package kec_pkg;

  localparam int ANGLE_BITS_DEF = 32;
  localparam int ITERS          = 30;

  // CORDIC datapath widths
  localparam int RW = 36;   // rotation x/y
  localparam int VW = 40;   // vectoring x/y
  localparam int ZW = 34;   // angle accumulators

  localparam logic signed [RW-1:0] GAIN_INV  = RW'(652032874);
  localparam longint               ONE_Q60   = 64'sd1 << 60;
  localparam longint               UNREACH_Q60 = 64'sd402445517400000;
  localparam logic [31:0]          HALF_TURN = 32'h8000_0000;
  localparam logic [31:0]          QUARTER_TURN = 32'h4000_0000;

  // Register reset values
  localparam logic signed [31:0] COS_RST   = 32'sd690187931;
  localparam logic [30:0]        SIN_RST   = 31'd822533911;

  typedef enum logic [1:0] {
    REG_COS   = 2'd0,
    REG_SIN   = 2'd1,
    REG_SENSE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] cos_offset;
    logic [30:0]        sin_offset;
    logic               sense;
  } cfg_t;

  // atan(2^-i) in 32-bit binary angle
  function automatic logic [ZW-1:0] atan_tab(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
      27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return ZW'(v);
  endfunction

endpackage

// File: design/kec_front.sv
// Input queue: two-entry buffer between the stream port and the back pipeline.
module kec_front import kec_pkg::*; #(
  parameter int DW = 1 + 3 * ANGLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          vld_o,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] mem_q [0:1];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          push_w, pop_w;

  assign ready_o = (cnt_q != 2'd2);
  assign vld_o   = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign push_w  = push_i && ready_o;
  assign pop_w   = pop_i && vld_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_w) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_w) wr_q <= ~wr_q;
      if (pop_w)  rd_q <= ~rd_q;
      if (push_w && !pop_w)      cnt_q <= cnt_q + 2'd1;
      else if (!push_w && pop_w) cnt_q <= cnt_q - 2'd1;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue fill out of range");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_w && !pop_w) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue fill did not grow on push");
  a_cnt_dn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_w && pop_w) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("queue fill did not shrink on pop");

endmodule

// File: design/kec_rot.sv
// Pipelined CORDIC rotation: cosine and sine of a 32-bit binary angle, one stage per iteration.
module kec_rot import kec_pkg::*; #(
  parameter int TW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [31:0]   z_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 vld_o,
  output logic signed [RW-1:0] cos_o,
  output logic signed [RW-1:0] sin_o,
  output logic [TW-1:0]        tag_o
);

  logic signed [RW-1:0] x [0:ITERS];
  logic signed [RW-1:0] y [0:ITERS];
  logic signed [ZW-1:0] z [0:ITERS];
  logic [TW-1:0]        tg [0:ITERS];
  logic                 v [0:ITERS];

  assign x[0]  = GAIN_INV;
  assign y[0]  = '0;
  assign z[0]  = ZW'(z_i);
  assign tg[0] = tag_i;
  assign v[0]  = vld_i;

  for (genvar k = 0; k < ITERS; k++) begin : g_stage
    // one micro-rotation per stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tg[k+1] <= tg[k];
        if (!z[k][ZW-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - signed'(atan_tab(k));
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + signed'(atan_tab(k));
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (en_i) begin
        v[k+1] <= v[k];
      end
    end
  end

  assign vld_o = v[ITERS];
  assign cos_o = x[ITERS];
  assign sin_o = y[ITERS];
  assign tag_o = tg[ITERS];

endmodule

// File: design/kec_isqrt.sv
// Pipelined restoring integer square root of a 64-bit value, one result bit per stage.
module kec_isqrt import kec_pkg::*; #(
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [63:0]   val_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [32:0]   root_o,
  output logic [TW-1:0] tag_o
);

  localparam int STEPS = 32;

  logic [63:0]   rem [0:STEPS];
  logic [63:0]   r   [0:STEPS];
  logic [TW-1:0] tg  [0:STEPS];
  logic          v   [0:STEPS];

  assign rem[0] = val_i;
  assign r[0]   = '0;
  assign tg[0]  = tag_i;
  assign v[0]   = vld_i;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] B = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = r[k] + B;
    // restoring step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tg[k+1] <= tg[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          r[k+1]   <= (r[k] >> 1) + B;
        end else begin
          rem[k+1] <= rem[k];
          r[k+1]   <= r[k] >> 1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (en_i) begin
        v[k+1] <= v[k];
      end
    end
  end

  assign vld_o  = v[STEPS];
  assign root_o = r[STEPS][32:0];
  assign tag_o  = tg[STEPS];

endmodule

// File: design/kec_vec.sv
// Pipelined CORDIC vectoring, two atan2 lanes side by side.
module kec_vec import kec_pkg::*; #(
  parameter int TW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [VW-1:0] y0_i,
  input  logic signed [VW-1:0] x0_i,
  input  logic signed [VW-1:0] y1_i,
  input  logic signed [VW-1:0] x1_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 vld_o,
  output logic [31:0]          ang0_o,
  output logic [31:0]          ang1_o,
  output logic [TW-1:0]        tag_o
);

  logic signed [VW-1:0] x [0:1][0:ITERS];
  logic signed [VW-1:0] y [0:1][0:ITERS];
  logic signed [ZW-1:0] z [0:1][0:ITERS];
  logic [TW-1:0]        tg [0:ITERS];
  logic                 v  [0:ITERS];

  assign x[0][0] = x0_i;
  assign y[0][0] = y0_i;
  assign x[1][0] = x1_i;
  assign y[1][0] = y1_i;
  assign z[0][0] = '0;
  assign z[1][0] = '0;
  assign tg[0]   = tag_i;
  assign v[0]    = vld_i;

  for (genvar k = 0; k < ITERS; k++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      // drive y toward zero
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (y[l][k] > 0) begin
            x[l][k+1] <= x[l][k] + (y[l][k] >>> k);
            y[l][k+1] <= y[l][k] - (x[l][k] >>> k);
            z[l][k+1] <= z[l][k] + signed'(atan_tab(k));
          end else if (y[l][k] < 0) begin
            x[l][k+1] <= x[l][k] - (y[l][k] >>> k);
            y[l][k+1] <= y[l][k] + (x[l][k] >>> k);
            z[l][k+1] <= z[l][k] - signed'(atan_tab(k));
          end else begin
            x[l][k+1] <= x[l][k];
            y[l][k+1] <= y[l][k];
            z[l][k+1] <= z[l][k];
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tg[k+1] <= tg[k];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (en_i) begin
        v[k+1] <= v[k];
      end
    end
  end

  assign vld_o  = v[ITERS];
  assign ang0_o = z[0][ITERS][31:0];
  assign ang1_o = z[1][ITERS][31:0];
  assign tag_o  = tg[ITERS];

endmodule

// File: design/kec_back.sv
// Conversion pipeline: sin/cos, products, square root, two atan2 lanes, output register.
module kec_back import kec_pkg::*; #(
  parameter int AB = ANGLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          vld_i,
  input  logic [3*AB:0] data_i,
  output logic          pop_o,
  output logic          out_vld_o,
  input  logic          out_rdy_i,
  output logic [AB-1:0] out_omega_o,
  output logic [AB-1:0] out_phi_o,
  output logic [AB-1:0] out_third_o
);

  localparam int SH  = (AB >= 32) ? AB - 32 : 32 - AB;
  localparam int TW1 = 1 + 2 * AB;          // kind, omega, phi
  localparam int TW2 = TW1 + 1 + 3 * VW;    // + unreach, y0, y1, c
  localparam int TW3 = TW1 + 1;             // kind, omega, phi, unreach

  function automatic logic [AB-1:0] from32(input logic [31:0] a);
    if (AB >= 32) return AB'(a) << SH;
    else          return AB'(a >> SH);
  endfunction

  logic en;
  logic out_vld_q;

  // whole pipeline moves unless the result register is held
  assign en        = !out_vld_q || out_rdy_i;
  assign pop_o     = en && vld_i;
  assign out_vld_o = out_vld_q;

  // unpack beat and form half angle
  logic          kind_w;
  logic [AB-1:0] om_w, ph_w, th_w;
  logic [31:0]   th32, half32;

  assign kind_w = data_i[3*AB];
  assign om_w   = data_i[AB-1:0];
  assign ph_w   = data_i[2*AB-1:AB];
  assign th_w   = data_i[3*AB-1:2*AB];

  always_comb begin
    if (AB >= 32) th32 = 32'(th_w >> SH);
    else          th32 = 32'(th_w) << SH;
    half32 = {th32[31], th32[31:1]};
  end

  logic                 v_r;
  logic signed [RW-1:0] c_r, s_r;
  logic [TW1-1:0]       tg_r;

  kec_rot #(.TW(TW1)) u_rot (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld_i), .z_i(signed'(half32)),
    .tag_i({kind_w, om_w, ph_w}),
    .vld_o(v_r), .cos_o(c_r), .sin_o(s_r), .tag_o(tg_r)
  );

  // stage M1: products of sin
  logic                 v1_q, v2_q, v3_q, v4_q;
  logic [TW1-1:0]       tg1_q, tg2_q, tg3_q, tg4_q;
  logic signed [63:0]   p1_q, ts1_q;
  logic signed [63:0]   ss1_q;
  logic [61:0]          so2_q;
  logic signed [RW-1:0] c1_q, c2_q, c3_q, s1_q, s2_q, s3_q;
  logic signed [31:0]   so_s;
  logic signed [31:0]   s32;

  assign so_s = signed'({1'b0, cfg_i.sin_offset});
  // sine magnitude stays at or below about 2^30, so 32 bits carry it
  assign s32  = s_r[31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q  <= cfg_i.cos_offset * s32;
      ts1_q <= so_s * s32;
      ss1_q <= s32 * s32;
      so2_q <= cfg_i.sin_offset * cfg_i.sin_offset;
      c1_q  <= c_r;
      s1_q  <= s_r;
      tg1_q <= tg_r;
    end
  end

  // stage M2: rescale, reach margin
  logic signed [VW-1:0] ya2_q, t2_q, ya3_q, t3_q, ya4_q, y04_q;
  logic signed [72:0]   q2_q, q3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ya2_q <= VW'(p1_q >>> 30);
      t2_q  <= VW'(ts1_q >>> 30);
      q2_q  <= 73'(signed'({1'b0, so2_q})) - 73'(ss1_q);
      c2_q  <= c1_q;
      s2_q  <= s1_q;
      tg2_q <= tg1_q;
    end
  end

  // stage M3: t squared (t stays below 2^32 in magnitude)
  logic signed [32:0] t33;
  logic signed [65:0] tt3_q;

  assign t33 = t2_q[32:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tt3_q <= t33 * t33;
      q3_q  <= q2_q;
      t3_q  <= t2_q;
      ya3_q <= ya2_q;
      c3_q  <= c2_q;
      s3_q  <= s2_q;
      tg3_q <= tg2_q;
    end
  end

  // stage M4: radicand and reach check
  logic signed [79:0]   dif;
  logic [63:0]          d4_q;
  logic                 un4_q;
  logic signed [VW-1:0] c4_q;
  logic                 kind3;

  assign kind3 = tg3_q[TW1-1];
  assign dif   = 80'(ONE_Q60) - 80'(tt3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (kind3) d4_q <= q3_q[63:0];
      else       d4_q <= dif[79] ? 64'(-dif) : dif[63:0];
      un4_q <= kind3 && (q3_q < 73'(UNREACH_Q60));
      y04_q <= kind3 ? VW'(s3_q) : t3_q;
      ya4_q <= ya3_q;
      c4_q  <= VW'(c3_q);
      tg4_q <= tg3_q;
    end
  end

  // valid bits of the product stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= v_r;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  logic                 v_s;
  logic [32:0]          root;
  logic [TW2-1:0]       tg_s;
  logic [TW1-1:0]       tg1_s;
  logic                 un_s;
  logic signed [VW-1:0] y0_s, ya_s, c_s, root_v;

  kec_isqrt #(.TW(TW2)) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v4_q), .val_i(d4_q),
    .tag_i({tg4_q, un4_q, y04_q, ya4_q, c4_q}),
    .vld_o(v_s), .root_o(root), .tag_o(tg_s)
  );

  assign {tg1_s, un_s, y0_s, ya_s, c_s} = tg_s;
  assign root_v = VW'(signed'({1'b0, root}));

  logic           v_v;
  logic [31:0]    ang0, ang1;
  logic [TW3-1:0] tg_v;

  kec_vec #(.TW(TW3)) u_vec (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_s),
    .y0_i(y0_s), .x0_i(root_v),
    .y1_i(ya_s), .x1_i(tg1_s[TW1-1] ? root_v : c_s),
    .tag_i({tg1_s, un_s}),
    .vld_o(v_v), .ang0_o(ang0), .ang1_o(ang1), .tag_o(tg_v)
  );

  // final corrections
  logic          kind_v, un_v;
  logic [AB-1:0] om_v, ph_v, corr_a, third_a;
  logic [31:0]   corr32, third32;

  assign {kind_v, om_v, ph_v, un_v} = tg_v;
  assign corr32  = un_v ? QUARTER_TURN : ang1;
  assign third32 = un_v ? HALF_TURN : {ang0[30:0], 1'b0};
  assign corr_a  = from32(corr32);
  assign third_a = from32(third32);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_omega_o <= (cfg_i.sense ^ kind_v) ? om_v + corr_a : om_v - corr_a;
      out_phi_o   <= kind_v ? ph_v - corr_a : ph_v + corr_a;
      out_third_o <= third_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v_v;
    end
  end

endmodule

// File: design/kappa_euler_angle_converter.sv
// Top level: register port, input queue and conversion pipeline.
//
//  channel   dir  beat contents
//  s_axis    in   tuser: kind; tdata: omega, phi, third (kappa or chi)
//  m_axis    out  tdata: omega, phi, third (chi or kappa)
//  apb       in   cos_offset @0x0, sin_offset @0x4, rotation_sense @0x8
//
// One beat per cycle while results are accepted; from queue head to result
// a beat passes the rotation CORDIC (30), product stages (4), square root
// (32), vectoring CORDIC (30) and the result register.
// Reset clears the queue, stage valid bits and registers to defaults.
// A held result freezes the whole pipeline; the queue keeps taking beats
// until both entries are full.
module kappa_euler_angle_converter import kec_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // omega, phi, third
  input  logic                             s_axis_tuser,  // kind
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [((3*ANGLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // omega, phi, third
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int AB = ANGLE_BITS;
  localparam int DW = ((3 * AB + 7) / 8) * 8;

  // configuration registers
  cfg_t     cfg_q;
  cfg_reg_e reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_offset <= COS_RST;
      cfg_q.sin_offset <= SIN_RST;
      cfg_q.sense      <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_COS:   cfg_q.cos_offset <= pwdata;
        REG_SIN:   cfg_q.sin_offset <= pwdata[30:0];
        REG_SENSE: cfg_q.sense      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COS:   prdata = cfg_q.cos_offset;
      REG_SIN:   prdata = {1'b0, cfg_q.sin_offset};
      REG_SENSE: prdata = {31'b0, cfg_q.sense};
      default:   prdata = '0;
    endcase
  end

  // input queue
  logic          q_vld, q_pop;
  logic [3*AB:0] q_data;

  kec_front #(.DW(3 * AB + 1)) u_front (
    .clk_i, .rst_ni,
    .push_i(s_axis_tvalid), .data_i({s_axis_tuser, s_axis_tdata[3*AB-1:0]}),
    .ready_o(s_axis_tready),
    .pop_i(q_pop), .vld_o(q_vld), .data_o(q_data)
  );

  // conversion pipeline
  logic [AB-1:0] om, ph, th;

  kec_back #(.AB(AB)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .vld_i(q_vld), .data_i(q_data), .pop_o(q_pop),
    .out_vld_o(m_axis_tvalid), .out_rdy_i(m_axis_tready),
    .out_omega_o(om), .out_phi_o(ph), .out_third_o(th)
  );

  assign m_axis_tdata = DW'({th, ph, om});

endmodule
